[rtl/tsc_pkg.sv]
package tsc_pkg;

  localparam int VTX_W      = 16;
  localparam int RATE_REG_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_BITS_DEF         = 4;
  localparam int MAX_RATE_DEF          = 4;
  localparam int SAMPLE_COORD_BITS_DEF = 14;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_V0X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V0Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V1X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V1Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V2X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V2Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 3'd6;

  typedef struct packed {
    logic signed [VTX_W-1:0] x;
    logic signed [VTX_W-1:0] y;
  } vtx_t;

  typedef vtx_t [2:0] tri_t;

endpackage

[rtl/triangle_sample_coverage_top.sv]
// Triangle sample coverage.
// Write the three vertices (signed, FRAC_BITS fraction bits) and the
// samples-per-axis rate through the cfg write port while no word is in
// flight. Each word on the s_axis channel names one supersample (column,
// row); for each one a word leaves on m_axis carrying the covered flag and
// the coordinates, in the order the samples came in.
// The path is four register stages: scaling, differences, the edge
// multiplies, then the edge sums and the top-left tie test. One sample is taken
// every cycle while m_axis does not stall.
// A stall on m_axis holds the output word; the stages behind it keep
// filling until all four hold a word, and only then s_axis_tready drops.
// Reset empties the pipeline, clears the vertices to zero and sets the
// rate to one.
module triangle_sample_coverage_top import tsc_pkg::*; #(
  parameter int FRAC_BITS         = FRAC_BITS_DEF,
  parameter int MAX_RATE          = MAX_RATE_DEF,
  parameter int SAMPLE_COORD_BITS = SAMPLE_COORD_BITS_DEF,
  localparam int CB  = SAMPLE_COORD_BITS,
  localparam int INW = ((2 * CB + 7) / 8) * 8,
  localparam int OW  = ((2 * CB + 1 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [INW-1:0]        s_axis_tdata,   // sample_col, sample_row
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OW-1:0]         m_axis_tdata    // covered, out_col, out_row
);

  localparam int RB  = $clog2(MAX_RATE + 1);
  localparam int SW  = VTX_W + 2 + RB;                   // scaled vertex
  localparam int PW  = CB + 2 + FRAC_BITS;               // scaled sample centre
  localparam int DW  = SW + 1;                           // edge delta
  localparam int QW  = ((PW > SW) ? PW : SW) + 1;        // centre minus vertex
  localparam int PRW = DW + QW;
  localparam int EW  = PRW + 1;
  localparam int WPW = 2 * DW;
  localparam int WW  = WPW + 1;

  tri_t          tri_c;
  logic [RB-1:0] rate_c;

  tsc_cfg_regs #(.MAX_RATE(MAX_RATE)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tri_o       (tri_c),
    .rate_o      (rate_c)
  );

  // stage enables, back to front
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: scale vertices by 2*rate, sample centre by 2^(FRAC_BITS+1)
  logic [CB-1:0]          col_in, row_in;
  logic [PW-1:0]          pxu, pyu;
  logic signed [SW-1:0]   sx_d [3], sy_d [3];
  logic signed [SW-1:0]   rate_s;
  logic [CB-1:0]          col1_q, row1_q;
  logic signed [PW-1:0]   px1_q, py1_q;
  logic signed [SW-1:0]   sx1_q [3], sy1_q [3];

  assign col_in = s_axis_tdata[CB-1:0];
  assign row_in = s_axis_tdata[2*CB-1:CB];
  assign pxu    = PW'({col_in, 1'b1}) << FRAC_BITS;
  assign pyu    = PW'({row_in, 1'b1}) << FRAC_BITS;
  assign rate_s = SW'($signed({1'b0, rate_c}));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx_d[i] = (SW'(tri_c[i].x) * rate_s) <<< 1;
      sy_d[i] = (SW'(tri_c[i].y) * rate_s) <<< 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      col1_q <= col_in;
      row1_q <= row_in;
      px1_q  <= $signed(pxu);
      py1_q  <= $signed(pyu);
      for (int i = 0; i < 3; i++) begin
        sx1_q[i] <= sx_d[i];
        sy1_q[i] <= sy_d[i];
      end
    end
  end

  // stage 2: edge deltas and centre offsets from each edge start
  logic [CB-1:0]        col2_q, row2_q;
  logic signed [DW-1:0] dx2_q [3], dy2_q [3];
  logic signed [QW-1:0] qx2_q [3], qy2_q [3];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      col2_q <= col1_q;
      row2_q <= row1_q;
      for (int i = 0; i < 3; i++) begin
        dx2_q[i] <= DW'(sx1_q[(i + 1) % 3]) - DW'(sx1_q[i]);
        dy2_q[i] <= DW'(sy1_q[(i + 1) % 3]) - DW'(sy1_q[i]);
        qx2_q[i] <= QW'(px1_q) - QW'(sx1_q[i]);
        qy2_q[i] <= QW'(py1_q) - QW'(sy1_q[i]);
      end
    end
  end

  // stage 3: edge products and the winding products
  logic [CB-1:0]         col3_q, row3_q;
  logic signed [DW-1:0]  dx3_q [3], dy3_q [3];
  logic signed [PRW-1:0] ma3_q [3], mb3_q [3];
  logic signed [WPW-1:0] wa3_q, wb3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      col3_q <= col2_q;
      row3_q <= row2_q;
      wa3_q  <= WPW'(dx2_q[0]) * WPW'(dy2_q[2]);
      wb3_q  <= WPW'(dy2_q[0]) * WPW'(dx2_q[2]);
      for (int i = 0; i < 3; i++) begin
        dx3_q[i] <= dx2_q[i];
        dy3_q[i] <= dy2_q[i];
        ma3_q[i] <= PRW'(dy2_q[i]) * PRW'(qx2_q[i]);
        mb3_q[i] <= PRW'(dx2_q[i]) * PRW'(qy2_q[i]);
      end
    end
  end

  // stage 4: edge values, winding and the top-left tie rule
  logic signed [EW-1:0] e_c [3];
  logic signed [WW-1:0] wind_c;
  logic [2:0]           ok_c;
  logic                 cov_c, pos_c;
  logic                 cov4_q;
  logic [CB-1:0]        col4_q, row4_q;

  always_comb begin
    wind_c = WW'(wa3_q) - WW'(wb3_q);
    pos_c  = wind_c > 0;
    for (int i = 0; i < 3; i++) begin
      e_c[i] = EW'(ma3_q[i]) - EW'(mb3_q[i]);
      if (pos_c) begin
        ok_c[i] = (e_c[i] > 0) || ((e_c[i] == 0) &&
                  ((dy3_q[i] > 0) || ((dy3_q[i] == 0) && (dx3_q[i] > 0))));
      end else begin
        ok_c[i] = (e_c[i] < 0) || ((e_c[i] == 0) &&
                  ((dy3_q[i] < 0) || ((dy3_q[i] == 0) && (dx3_q[i] < 0))));
      end
    end
    cov_c = (wind_c != 0) && (&ok_c);
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      cov4_q <= cov_c;
      col4_q <= col3_q;
      row4_q <= row3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = OW'({row4_q, col4_q, cov4_q});

  // checks
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input blocked while a stage is empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted word missing from first stage");

  a_zero_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && (wa3_q == wb3_q)) |=> !m_axis_tdata[0])
    else $error("zero-area triangle reported as covering");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && m_axis_tready && !v3_q) |=> !m_axis_tvalid)
    else $error("output word repeated after it was taken");

endmodule

[rtl/tsc_cfg_regs.sv]
module tsc_cfg_regs import tsc_pkg::*; #(
  parameter int MAX_RATE = MAX_RATE_DEF,
  localparam int RB = $clog2(MAX_RATE + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output tri_t                  tri_o,
  output logic [RB-1:0]         rate_o
);

  tri_t                  tri_q;
  logic [RATE_REG_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q  <= '0;
      rate_q <= RATE_REG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_V0X:  tri_q[0].x <= cfg_wdata_i;
        REG_V0Y:  tri_q[0].y <= cfg_wdata_i;
        REG_V1X:  tri_q[1].x <= cfg_wdata_i;
        REG_V1Y:  tri_q[1].y <= cfg_wdata_i;
        REG_V2X:  tri_q[2].x <= cfg_wdata_i;
        REG_V2Y:  tri_q[2].y <= cfg_wdata_i;
        REG_RATE: rate_q     <= cfg_wdata_i[RATE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one, anything past the limit saturates
  always_comb begin
    priority if (rate_q == '0) begin
      rate_o = RB'(1);
    end else if (int'(rate_q) > MAX_RATE) begin
      rate_o = RB'(MAX_RATE);
    end else begin
      rate_o = RB'(rate_q);
    end
  end

  assign tri_o = tri_q;

endmodule
